FILE: src/linear_probe_hash_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hash table.
// Property forms used by the hash table module, which checks its own logic.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// An implication checked on every clock edge outside reset.
`define LPHT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// A consequence that must hold in the cycle after a condition.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Hash table package
// Sizes, codes and the FNV-1 constants shared by the hash table modules.
// ----------------------------------------------------------------------------
package lpht_pkg;
    localparam int Capacity = 1024;
    localparam int KeyBytes = 8;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = IdxW + 1;
    localparam int LenW = 4;
    localparam int SlotW = 1 + LenW + 64 + 64;

    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

    localparam logic [1:0] MODE_FIND = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_GET_INS = 2'd2;

    localparam logic [2:0] ST_MISS = 3'd0;
    localparam logic [2:0] ST_HIT = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_PRESENT = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    localparam logic [CntW-1:0] LOAD_LIMIT = CntW'((Capacity * 3 + 3) / 4);

    typedef struct packed {
        logic start;
        logic [63:0] key;
        logic [LenW-1:0] len;
    } hash_req_t;
endpackage

FILE: src/lpht_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: src/lpht_hash.sv
// ----------------------------------------------------------------------------
// FNV-1 hash unit
// Processes one key byte per cycle: multiply by the prime, then xor.
// ----------------------------------------------------------------------------
module lpht_hash
    import lpht_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  hash_req_t       req,
    output logic            done,
    output logic [IdxW-1:0] home
);
    logic [63:0] h_reg, h_next;
    logic [63:0] k_reg, k_next;
    logic [LenW-1:0] n_reg, n_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [63:0] prod;

    // Prime is 2^40 + 0x1b3, so the product is a shift plus a narrow multiply.
    assign prod = (h_reg << 40) + (h_reg * 64'h1b3);

    always_comb
    begin
        h_next = h_reg;
        k_next = k_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            h_next = FNV_OFFSET;
            k_next = req.key;
            n_next = req.len;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (n_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                h_next = prod ^ {56'd0, k_reg[7:0]};
                k_next = k_reg >> 8;
                n_next = n_reg - LenW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        k_reg <= k_next;
        n_reg <= n_next;
    end

    assign done = done_reg;
    assign home = h_reg[IdxW-1:0];
endmodule

FILE: src/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// Linear probing hash table
// Key/value store with FNV-1 home slots and linear probing in one RAM.
// ----------------------------------------------------------------------------
// Raise start with mode, key_bytes, key_len and value while busy is low; the
// word is taken at that edge and busy rises.
// Exactly one result word follows: done is high for one cycle with status
// and found_value. Busy stays high through that cycle and falls at the edge
// that ends it, so the next word can be taken in the cycle after the strobe.
// The strobe follows the hashing of the key bytes plus a slot read and a
// compare per probed slot, since each slot read passes through the single
// RAM port with its registered read data. An insert writes its slot in the
// strobe cycle and adds no time. A find on an empty table skips the probe,
// and a bad word gets its strobe in the cycle right after it is taken.
// Reset clears the state machine and the entry count; a clearing pass then
// writes each of the 1024 slots empty while busy is held high.
// The receiver cannot stall; done is a strobe.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [63:0] key_bytes,
    input  logic [3:0]  key_len,
    input  logic [63:0] value,
    output logic        done,
    output logic [2:0]  status,
    output logic [63:0] found_value
);
    `include "linear_probe_hash_table_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CMP = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] mode_reg;
    logic [63:0] key_reg;
    logic [LenW-1:0] len_reg;
    logic [63:0] val_reg;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic [CntW-1:0] n_reg, n_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [2:0] st_reg, st_next;
    logic [63:0] fv_reg, fv_next;
    logic ins_reg, ins_next;

    logic bad;
    logic [63:0] mkey;
    logic hdone;
    logic [IdxW-1:0] home;
    hash_req_t hreq;
    logic clearing;
    logic we;
    logic [SlotW-1:0] wdata;
    logic [SlotW-1:0] rdata;
    logic slot_v;
    logic match;

    assign bad = (mode != MODE_FIND && mode != MODE_INSERT && mode != MODE_GET_INS)
        || key_len == '0 || key_len > LenW'(KeyBytes)
        || (mode != MODE_FIND && value == '0);

    always_comb
    begin
        mkey = key_bytes;
        if (key_len < 4'd8)
        begin
            mkey = key_bytes & ((64'd1 << {key_len[2:0], 3'b000}) - 64'd1);
        end
    end

    assign hreq.start = start && !busy && !bad;
    assign hreq.key = mkey;
    assign hreq.len = key_len;

    lpht_hash u_hash (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (hreq),
        .done (hdone),
        .home (home)
    );

    assign clearing = state_reg == S_CLEAR;
    assign we = ins_reg || clearing;
    assign wdata = clearing ? '0 : {1'b1, len_reg, key_reg, val_reg};

    lpht_ram #(.Width(SlotW), .Depth(Capacity)) u_slots (
        .clk  (clk),
        .we   (we),
        .addr (idx_reg),
        .wdata(wdata),
        .rdata(rdata)
    );

    assign slot_v = rdata[SlotW-1];
    assign match = rdata[SlotW-2 -: LenW] == len_reg && rdata[127:64] == key_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        count_next = count_reg;
        st_next = st_reg;
        fv_next = fv_reg;
        ins_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + IdxW'(1);
                if (idx_reg == IdxW'(Capacity - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && bad)
                begin
                    st_next = ST_INVALID;
                    fv_next = '0;
                    state_next = S_DONE;
                end
                else if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hdone)
                begin
                    idx_next = home;
                    n_next = '0;
                    if (mode_reg == MODE_FIND && count_reg == '0)
                    begin
                        st_next = ST_MISS;
                        fv_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                fv_next = '0;
                state_next = S_DONE;
                if (!slot_v)
                begin
                    if (mode_reg == MODE_FIND)
                    begin
                        st_next = ST_MISS;
                    end
                    else if (count_reg >= LOAD_LIMIT)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        st_next = ST_INSERTED;
                        ins_next = 1'b1;
                        count_next = count_reg + CntW'(1);
                    end
                end
                else if (match)
                begin
                    st_next = (mode_reg == MODE_FIND) ? ST_HIT : ST_PRESENT;
                    fv_next = rdata[63:0];
                end
                else if (n_reg == CntW'(Capacity - 1))
                begin
                    st_next = (mode_reg == MODE_FIND) ? ST_MISS : ST_FULL;
                end
                else
                begin
                    idx_next = idx_reg + IdxW'(1);
                    n_next = n_reg + CntW'(1);
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            count_reg <= '0;
            ins_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            count_reg <= count_next;
            ins_reg <= ins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg <= mode;
            key_reg <= mkey;
            len_reg <= key_len;
            val_reg <= value;
        end
        n_reg <= n_next;
        st_reg <= st_next;
        fv_reg <= fv_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;
    assign status = st_reg;
    assign found_value = fv_reg;

    `LPHT_ASSERT_IMP(a_count_limit, clk, rst_n, 1'b1, count_reg <= LOAD_LIMIT)
    `LPHT_ASSERT_NEXT(a_ins_done, clk, rst_n, ins_reg, state_reg == S_IDLE)
    `LPHT_ASSERT_IMP(a_clear_quiet, clk, rst_n, clearing, busy && !done && !ins_reg)
    `LPHT_ASSERT_IMP(a_hit_value, clk, rst_n,
        done && status != ST_HIT && status != ST_PRESENT, found_value == '0)
endmodule

FILE: test/tb_linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// Linear probing hash table testbench
// Drives find, insert, get-or-insert and invalid words in random bursts and checks
// each result against an in-bench model of the table and its load limit.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_BAD = 2'd3;
    localparam int IdleLimit = 50000;

    typedef struct {
        logic [1:0]  mode;
        logic [63:0] key;
        logic [3:0]  len;
        logic [63:0] value;
    } word_t;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] value;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [63:0] key_bytes;
    logic [3:0]  key_len;
    logic [63:0] value;
    logic        done;
    logic [2:0]  status;
    logic [63:0] found_value;

    word_t   pending_q[$];
    answer_t answer_q[$];
    word_t   known_q[$];

    logic        tbl_valid[Capacity];
    logic [63:0] tbl_key[Capacity];
    logic [3:0]  tbl_len[Capacity];
    logic [63:0] tbl_value[Capacity];
    int          tbl_count;

    int errors;
    int accepted_n;
    int sent_n;
    int burst_left;
    int gap_left;
    int idle_cycles;
    int status_seen[8];

    linear_probe_hash_table u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .key_bytes(key_bytes),
        .key_len(key_len),
        .value(value),
        .done(done),
        .status(status),
        .found_value(found_value)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] masked_key(logic [63:0] k, logic [3:0] len);
        if (len >= 8)
            return k;
        return k & ((64'd1 << (8 * len)) - 64'd1);
    endfunction

    function automatic int fnv_home(logic [63:0] k, logic [3:0] len);
        logic [63:0] h;
        h = FNV_OFFSET;
        for (int i = 0; i < len; i++)
        begin
            h = h * FNV_PRIME;
            h = h ^ {56'd0, k[8*i +: 8]};
        end
        return int'(h % Capacity);
    endfunction

    task automatic lookup_answer(input word_t w, output answer_t a);
        logic [63:0] k;
        int          idx;
        int          slot;
        logic        hit;
        a.status = ST_INVALID;
        a.value = 64'd0;
        if (w.mode == MODE_BAD || w.len == 0 || w.len > KeyBytes
            || (w.mode != MODE_FIND && w.value == 64'd0))
            return;
        k = masked_key(w.key, w.len);
        idx = fnv_home(k, w.len);
        slot = Capacity;
        hit = 1'b0;
        for (int n = 0; n < Capacity; n++)
        begin
            if (!tbl_valid[idx])
            begin
                slot = idx;
                break;
            end
            if (tbl_len[idx] == w.len && tbl_key[idx] == k)
            begin
                slot = idx;
                hit = 1'b1;
                break;
            end
            idx = (idx + 1) % Capacity;
        end
        if (w.mode == MODE_FIND)
        begin
            if (tbl_count != 0 && hit)
            begin
                a.status = ST_HIT;
                a.value = tbl_value[slot];
            end
            else
                a.status = ST_MISS;
        end
        else if (hit)
        begin
            a.status = ST_PRESENT;
            a.value = tbl_value[slot];
        end
        else if (tbl_count * 4 >= Capacity * 3 || slot >= Capacity)
            a.status = ST_FULL;
        else
        begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot] = k;
            tbl_len[slot] = w.len;
            tbl_value[slot] = w.value;
            tbl_count = tbl_count + 1;
            a.status = ST_INSERTED;
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_nonzero();
        logic [63:0] v;
        v = rand64();
        return (v == 64'd0) ? 64'd1 : v;
    endfunction

    task automatic add_word(input logic [1:0] m, input logic [63:0] k,
                            input logic [3:0] len, input logic [63:0] v);
        word_t w;
        w.mode = m;
        w.key = k;
        w.len = len;
        w.value = v;
        pending_q.push_back(w);
        if (m != MODE_FIND && len >= 1 && len <= KeyBytes && known_q.size() < 2000)
            known_q.push_back(w);
    endtask

    task automatic add_random_word();
        word_t       w;
        int          pick;
        logic [63:0] junk;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(3))
                0: add_word(MODE_BAD, rand64(), 4'($urandom_range(15)), rand64());
                1: add_word(2'($urandom_range(2)), rand64(), 4'd0, rand64());
                2: add_word(2'($urandom_range(2)), rand64(), 4'($urandom_range(15, 9)),
                            rand64());
                default: add_word(2'($urandom_range(2, 1)), rand64(),
                                  4'($urandom_range(8, 1)), 64'd0);
            endcase
        end
        else if (pick < 55 || known_q.size() == 0)
            add_word(2'($urandom_range(2, 1)), rand64(), 4'($urandom_range(8, 1)),
                     rand_nonzero());
        else if (pick < 70)
            add_word(MODE_FIND, rand64(), 4'($urandom_range(8, 1)), rand64());
        else
        begin
            w = known_q[$urandom_range(known_q.size() - 1)];
            junk = rand64();
            if (w.len < 8)
                w.key = masked_key(w.key, w.len) | (junk & ~masked_key(~64'd0, w.len));
            add_word(2'($urandom_range(2)), w.key, w.len, rand_nonzero());
        end
    endtask

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            sent_n <= 0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (start && sent_n != accepted_n)
        begin
        end
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_q.size() > 0)
        begin
            start <= 1'b1;
            mode <= pending_q[0].mode;
            key_bytes <= pending_q[0].key;
            key_len <= pending_q[0].len;
            value <= pending_q[0].value;
            sent_n <= sent_n + 1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(30, 1);
                gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(20);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_a;
        word_t   w;
        if (!rst_n)
        begin
            accepted_n <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                status_seen[status] = status_seen[status] + 1;
                if (answer_q.size() == 0)
                begin
                    $error("result word with none expected: status %0d", status);
                    errors = errors + 1;
                end
                else
                begin
                    exp_a = answer_q.pop_front();
                    if (status !== exp_a.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_a.status, status);
                        errors = errors + 1;
                    end
                    if (found_value !== exp_a.value)
                    begin
                        $error("found_value: expected %h, actual %h", exp_a.value,
                               found_value);
                        errors = errors + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                w = pending_q.pop_front();
                lookup_answer(w, exp_a);
                answer_q.push_back(exp_a);
                accepted_n <= accepted_n + 1;
            end
            if (idle_cycles >= IdleLimit)
            begin
                $display("timeout: %0d words still expected", answer_q.size());
                $display("linear_probe_hash_table regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_FIND;
        key_bytes = 64'd0;
        key_len = 4'd0;
        value = 64'd0;
        errors = 0;
        tbl_count = 0;
        for (int i = 0; i < Capacity; i++)
            tbl_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;

        add_word(MODE_FIND, 64'h1234, 4'd2, 64'd0);
        add_word(MODE_BAD, 64'h1, 4'd1, 64'd5);
        add_word(MODE_INSERT, 64'h1, 4'd0, 64'd5);
        add_word(MODE_INSERT, 64'h1, 4'd9, 64'd5);
        add_word(MODE_FIND, 64'h1, 4'd15, 64'd5);
        add_word(MODE_INSERT, 64'h1, 4'd1, 64'd0);
        add_word(MODE_GET_INS, 64'h1, 4'd1, 64'd0);
        add_word(MODE_INSERT, 64'h0, 4'd1, 64'd7);
        add_word(MODE_INSERT, ~64'd0, 4'd8, ~64'd0);
        add_word(MODE_FIND, ~64'd0, 4'd8, 64'd0);
        add_word(MODE_FIND, 64'hffff_ff00, 4'd1, 64'd3);
        add_word(MODE_FIND, 64'h0, 4'd2, 64'd0);
        add_word(MODE_INSERT, 64'h0, 4'd2, 64'h8000_0000_0000_0000);
        add_word(MODE_INSERT, 64'h0, 4'd1, 64'd9);
        add_word(MODE_GET_INS, 64'h0, 4'd2, 64'd11);
        add_word(MODE_GET_INS, 64'hdead_beef_cafe, 4'd6, 64'h55);
        add_word(MODE_FIND, 64'hffff_dead_beef_cafe, 4'd6, 64'd0);
        add_word(MODE_GET_INS, 64'habcd_dead_beef_cafe, 4'd6, 64'd1);
        add_word(MODE_FIND, 64'hdead_beef_cafe, 4'd5, 64'd0);
        for (int i = 0; i < 1400; i++)
            add_random_word();

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() != 0 || answer_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d words: %0d miss, %0d hit, %0d inserted", accepted_n,
                 status_seen[ST_MISS], status_seen[ST_HIT], status_seen[ST_INSERTED]);
        $display("%0d already present, %0d full, %0d invalid; %0d entries at end",
                 status_seen[ST_PRESENT], status_seen[ST_FULL], status_seen[ST_INVALID],
                 tbl_count);
        if (errors == 0)
            $display("linear_probe_hash_table regression: pass");
        else
            $display("linear_probe_hash_table regression: fail");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/lpht_pkg.sv
src/lpht_ram.sv
src/lpht_hash.sv
src/linear_probe_hash_table.sv
test/tb_linear_probe_hash_table.sv
